// File: rtl/rmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Which quaternion component takes the half root; the others take the
   // three scaled off-diagonal terms.
   typedef enum logic [1:0] {
      SEL_W,
      SEL_X,
      SEL_Y,
      SEL_Z
   } sel_type;

endpackage
`default_nettype wire

// File: rtl/rmq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_req_if
// Matrix channel: nine signed fixed-point elements, row-major.
// ----------------------------------------------------------------------------
interface rmq_req_if #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r00;
   logic signed [DATA_WIDTH-1:0] r01;
   logic signed [DATA_WIDTH-1:0] r02;
   logic signed [DATA_WIDTH-1:0] r10;
   logic signed [DATA_WIDTH-1:0] r11;
   logic signed [DATA_WIDTH-1:0] r12;
   logic signed [DATA_WIDTH-1:0] r20;
   logic signed [DATA_WIDTH-1:0] r21;
   logic signed [DATA_WIDTH-1:0] r22;

   modport source (
      output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
      input  ready
   );
   modport sink (
      input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/rmq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_rsp_if
// Quaternion channel: w, x, y, z as signed fixed-point values.
// ----------------------------------------------------------------------------
interface rmq_rsp_if #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] qw;
   logic signed [DATA_WIDTH-1:0] qx;
   logic signed [DATA_WIDTH-1:0] qy;
   logic signed [DATA_WIDTH-1:0] qz;

   modport source (
      output valid, qw, qx, qy, qz,
      input  ready
   );
   modport sink (
      input  valid, qw, qx, qy, qz,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/rmq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front
// Two stages: trace and case selection, then root argument and the three
// off-diagonal terms.
// ----------------------------------------------------------------------------
module rmq_front #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   localparam int MaxWidth  = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS,
   localparam int ArgWidth  = MaxWidth + 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic signed [DATA_WIDTH-1:0] r00,
   input  wire logic signed [DATA_WIDTH-1:0] r01,
   input  wire logic signed [DATA_WIDTH-1:0] r02,
   input  wire logic signed [DATA_WIDTH-1:0] r10,
   input  wire logic signed [DATA_WIDTH-1:0] r11,
   input  wire logic signed [DATA_WIDTH-1:0] r12,
   input  wire logic signed [DATA_WIDTH-1:0] r20,
   input  wire logic signed [DATA_WIDTH-1:0] r21,
   input  wire logic signed [DATA_WIDTH-1:0] r22,
   output logic                              out_valid,
   output logic [ArgWidth-1:0]               out_arg,
   output logic signed [DATA_WIDTH:0]        out_d0,
   output logic signed [DATA_WIDTH:0]        out_d1,
   output logic signed [DATA_WIDTH:0]        out_d2,
   output rmq_pkg::sel_type                  out_sel
);
   import rmq_pkg::*;

   localparam int TrW  = DATA_WIDTH + 2;
   localparam int SumW = ArgWidth + 1;

   function automatic logic signed [DATA_WIDTH:0] dif(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      return (DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b);
   endfunction

   function automatic logic signed [DATA_WIDTH:0] add(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      return (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
   endfunction

   // Stage A
   logic                         vld_a_ff;
   logic signed [DATA_WIDTH-1:0] e_ff [9];
   logic signed [TrW-1:0]        trace_in, trace_ff;
   sel_type                      sel_in, sel_ff;
   logic                         row1, row2;
   logic signed [DATA_WIDTH-1:0] dmax;

   always_comb begin
      trace_in = TrW'(r00) + TrW'(r11) + TrW'(r22);
      row1     = r00 < r11;
      dmax     = row1 ? r11 : r00;
      row2     = dmax < r22;
      priority if (trace_in > 0) begin
         sel_in = SEL_W;
      end else if (row2) begin
         sel_in = SEL_Z;
      end else if (row1) begin
         sel_in = SEL_Y;
      end else begin
         sel_in = SEL_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0]  <= r00;
         e_ff[1]  <= r01;
         e_ff[2]  <= r02;
         e_ff[3]  <= r10;
         e_ff[4]  <= r11;
         e_ff[5]  <= r12;
         e_ff[6]  <= r20;
         e_ff[7]  <= r21;
         e_ff[8]  <= r22;
         trace_ff <= trace_in;
         sel_ff   <= sel_in;
      end
   end

   // Stage B
   logic signed [SumW-1:0]   base, arg_full;
   logic [ArgWidth-1:0]      arg_in, arg_ff;
   logic signed [DATA_WIDTH:0] d0_in, d1_in, d2_in, d0_ff, d1_ff, d2_ff;
   logic                     vld_b_ff;
   sel_type                  selb_ff;

   always_comb begin
      unique case (sel_ff)
         SEL_W: begin
            base  = SumW'(trace_ff);
            d0_in = dif(e_ff[5], e_ff[7]);
            d1_in = dif(e_ff[6], e_ff[2]);
            d2_in = dif(e_ff[1], e_ff[3]);
         end
         SEL_X: begin
            base  = SumW'(e_ff[0]) - SumW'(e_ff[4]) - SumW'(e_ff[8]);
            d0_in = dif(e_ff[5], e_ff[7]);
            d1_in = add(e_ff[1], e_ff[3]);
            d2_in = add(e_ff[2], e_ff[6]);
         end
         SEL_Y: begin
            base  = SumW'(e_ff[4]) - SumW'(e_ff[8]) - SumW'(e_ff[0]);
            d0_in = dif(e_ff[6], e_ff[2]);
            d1_in = add(e_ff[5], e_ff[7]);
            d2_in = add(e_ff[3], e_ff[1]);
         end
         SEL_Z: begin
            base  = SumW'(e_ff[8]) - SumW'(e_ff[0]) - SumW'(e_ff[4]);
            d0_in = dif(e_ff[1], e_ff[3]);
            d1_in = add(e_ff[6], e_ff[2]);
            d2_in = add(e_ff[7], e_ff[5]);
         end
         default: begin
            base  = '0;
            d0_in = '0;
            d1_in = '0;
            d2_in = '0;
         end
      endcase
      arg_full = base + (SumW'(1) << FRAC_BITS);
      // A negative argument only comes from a matrix that is not a rotation.
      arg_in   = arg_full[SumW-1] ? '0 : arg_full[ArgWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg_ff  <= arg_in;
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         selb_ff <= sel_ff;
      end
   end

   assign out_valid = vld_b_ff;
   assign out_arg   = arg_ff;
   assign out_d0    = d0_ff;
   assign out_d1    = d1_ff;
   assign out_d2    = d2_ff;
   assign out_sel   = selb_ff;

endmodule
`default_nettype wire

// File: rtl/rmq_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, then a rounding
// stage that raises the root when the remainder exceeds it.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
   parameter int ROOT_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [2*ROOT_WIDTH-1:0]   radicand,
   output logic                           out_valid,
   output logic [ROOT_WIDTH:0]            root
);
   localparam int RemW = ROOT_WIDTH + 2;

   logic                    vld_ff  [ROOT_WIDTH];
   logic [2*ROOT_WIDTH-1:0] rad_ff  [ROOT_WIDTH];
   logic [RemW-1:0]         rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]   root_ff [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
      logic                    vld_prev;
      logic [2*ROOT_WIDTH-1:0] rad_prev;
      logic [RemW-1:0]         rem_prev, rem_sh, trial, rem_in;
      logic [ROOT_WIDTH-1:0]   root_prev, root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // Bring down the next pair of radicand bits, most significant first.
      assign rem_sh = {rem_prev[RemW-3:0], rad_prev[2*(ROOT_WIDTH-1-k) +: 2]};
      assign trial  = {root_prev, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_prev;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   logic                  out_vld_ff;
   logic [ROOT_WIDTH:0]   root_out_in, root_out_ff;
   logic                  round_up;

   assign round_up    = rem_ff[ROOT_WIDTH-1] > RemW'(root_ff[ROOT_WIDTH-1]);
   assign root_out_in = {1'b0, root_ff[ROOT_WIDTH-1]} + (ROOT_WIDTH+1)'(round_up);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[ROOT_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_out_ff <= root_out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign root      = root_out_ff;

endmodule
`default_nettype wire

// File: rtl/rmq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined scaled part: d * 2^FRAC_BITS / (2*s), rounded half away from
// zero, saturated; zero when s is zero. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   parameter int ROOT_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic signed [DATA_WIDTH:0]   in_d,
   input  wire logic [ROOT_WIDTH:0]          in_s,
   output logic                              out_valid,
   output logic signed [DATA_WIDTH-1:0]      out_q
);
   localparam int MagW  = DATA_WIDTH + 1;
   localparam int QW    = DATA_WIDTH - 1;
   localparam int CmpW  = ((MagW + FRAC_BITS > ROOT_WIDTH + DATA_WIDTH) ?
                           MagW + FRAC_BITS : ROOT_WIDTH + DATA_WIDTH) + 2;

   logic              vld_ff  [QW+1];
   logic [CmpW-1:0]   rem_ff  [QW+1];
   logic [CmpW-1:0]   den_ff  [QW+1];
   logic [QW-1:0]     quo_ff  [QW+1];
   logic              neg_ff  [QW+1];
   logic              zero_ff [QW+1];
   logic              ovf_ff  [QW+1];

   // Prep stage: numerator with the rounding term, and the saturation test.
   logic [MagW-1:0] mag;
   logic [CmpW-1:0] num_in, den_in;
   logic            ovf_in;

   always_comb begin
      mag    = in_d[DATA_WIDTH] ? MagW'(-in_d) : MagW'(in_d);
      num_in = (CmpW'(mag) << FRAC_BITS) + CmpW'(in_s);
      den_in = CmpW'(in_s) << 1;
      ovf_in = num_in >= (den_in << QW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_in;
         den_ff[0]  <= den_in;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= in_d[DATA_WIDTH];
         zero_ff[0] <= in_s == '0;
         ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_bit
      logic [CmpW-1:0] sh;
      logic [CmpW-1:0] rem_in;
      logic [QW-1:0]   quo_in;

      always_comb begin
         sh = den_ff[j-1] << (QW - j);
         if (rem_ff[j-1] >= sh) begin
            rem_in = rem_ff[j-1] - sh;
            quo_in = quo_ff[j-1] | (QW'(1) << (QW - j));
         end else begin
            rem_in = rem_ff[j-1];
            quo_in = quo_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_ff[j-1];
            quo_ff[j]  <= quo_in;
            neg_ff[j]  <= neg_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
            ovf_ff[j]  <= ovf_ff[j-1];
         end
      end
   end

   logic                         out_vld_ff;
   logic signed [DATA_WIDTH-1:0] q_in, q_ff;

   always_comb begin
      priority if (zero_ff[QW]) begin
         q_in = '0;
      end else if (ovf_ff[QW]) begin
         // A magnitude of exactly the half range still fits when negative.
         q_in = neg_ff[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
      end else if (neg_ff[QW]) begin
         q_in = -{1'b0, quo_ff[QW]};
      end else begin
         q_in = {1'b0, quo_ff[QW]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_q     = q_ff;

endmodule
`default_nettype wire

// File: rtl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix to quaternion converter, Shepperd's method, fully pipelined.
//
// The req channel carries one 3x3 matrix per item, row-major, signed with
// FRAC_BITS fraction bits. The rsp channel returns one quaternion (w, x, y,
// z) per item in the same format, saturated, in input order.
// Throughput is one item per clock while rsp is not stalled. An item passes
// the front end, then the square root (one root bit per stage), then the
// divider (one quotient bit per stage), then the output register.
// Reset clears all valid bits; no item is in flight afterward.
// The whole pipeline advances only while the output register is empty or
// being taken; when rsp stalls, req_if.ready drops and every stage holds.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rmq_req_if.sink   req_if,
   rmq_rsp_if.source rsp_if
);
   import rmq_pkg::*;

   localparam int MaxWidth  = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS;
   localparam int ArgWidth  = MaxWidth + 2;
   localparam int RootWidth = (ArgWidth + FRAC_BITS + 1) / 2;
   localparam int SqLat     = RootWidth + 1;
   localparam int DivLat    = DATA_WIDTH + 1;
   localparam int SideW     = 2 + 3 * (DATA_WIDTH + 1);
   localparam int Side2W    = 2 + DATA_WIDTH;
   localparam int QW        = DATA_WIDTH - 1;

   logic en;
   logic rsp_vld_ff;

   assign en           = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = en;

   // Front end
   logic                       fr_valid;
   logic [ArgWidth-1:0]        fr_arg;
   logic signed [DATA_WIDTH:0] fr_d0, fr_d1, fr_d2;
   sel_type                    fr_sel;

   rmq_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .r00       (req_if.r00),
      .r01       (req_if.r01),
      .r02       (req_if.r02),
      .r10       (req_if.r10),
      .r11       (req_if.r11),
      .r12       (req_if.r12),
      .r20       (req_if.r20),
      .r21       (req_if.r21),
      .r22       (req_if.r22),
      .out_valid (fr_valid),
      .out_arg   (fr_arg),
      .out_d0    (fr_d0),
      .out_d1    (fr_d1),
      .out_d2    (fr_d2),
      .out_sel   (fr_sel)
   );

   // Two roots: the full root scales the parts, the half root is a component.
   logic [2*RootWidth-1:0] rad_s, rad_h;
   logic                   s_valid;
   logic [RootWidth:0]     s_root, h_root;

   assign rad_s = (2*RootWidth)'(fr_arg) << FRAC_BITS;
   assign rad_h = (2*RootWidth)'(fr_arg) << (FRAC_BITS - 2);

   rmq_sqrt #(.ROOT_WIDTH(RootWidth)) u_sqrt_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .radicand  (rad_s),
      .out_valid (s_valid),
      .root      (s_root)
   );

   rmq_sqrt #(.ROOT_WIDTH(RootWidth)) u_sqrt_h (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .radicand  (rad_h),
      .out_valid (),
      .root      (h_root)
   );

   // Terms and selection ride alongside the root pipeline.
   logic [SideW-1:0] side_in;
   logic [SideW-1:0] side_ff [SqLat];

   assign side_in = {fr_sel, fr_d2, fr_d1, fr_d0};

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < SqLat; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   sel_type                    sq_sel;
   logic signed [DATA_WIDTH:0] sq_d0, sq_d1, sq_d2;

   assign sq_sel = sel_type'(side_ff[SqLat-1][SideW-1 -: 2]);
   assign sq_d0  = signed'(side_ff[SqLat-1][DATA_WIDTH:0]);
   assign sq_d1  = signed'(side_ff[SqLat-1][2*DATA_WIDTH+1 -: DATA_WIDTH+1]);
   assign sq_d2  = signed'(side_ff[SqLat-1][3*DATA_WIDTH+2 -: DATA_WIDTH+1]);

   logic                         p_valid;
   logic signed [DATA_WIDTH-1:0] p0, p1, p2;

   rmq_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ROOT_WIDTH (RootWidth)
   ) u_div0 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_d      (sq_d0),
      .in_s      (s_root),
      .out_valid (p_valid),
      .out_q     (p0)
   );

   rmq_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ROOT_WIDTH (RootWidth)
   ) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_d      (sq_d1),
      .in_s      (s_root),
      .out_valid (),
      .out_q     (p1)
   );

   rmq_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ROOT_WIDTH (RootWidth)
   ) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_d      (sq_d2),
      .in_s      (s_root),
      .out_valid (),
      .out_q     (p2)
   );

   // Saturated half root and selection ride alongside the dividers.
   logic [DATA_WIDTH-1:0] half_sat;
   logic [Side2W-1:0]     side2_in;
   logic [Side2W-1:0]     side2_ff [DivLat];

   assign half_sat = ((h_root >> QW) != '0) ? {1'b0, {QW{1'b1}}}
                                           : DATA_WIDTH'(h_root);
   assign side2_in = {sq_sel, half_sat};

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff[0] <= side2_in;
         for (int i = 1; i < DivLat; i++) begin
            side2_ff[i] <= side2_ff[i-1];
         end
      end
   end

   sel_type                      dv_sel;
   logic signed [DATA_WIDTH-1:0] dv_half;

   assign dv_sel  = sel_type'(side2_ff[DivLat-1][Side2W-1 -: 2]);
   assign dv_half = signed'(side2_ff[DivLat-1][DATA_WIDTH-1:0]);

   // Output register
   logic signed [DATA_WIDTH-1:0] qw_in, qx_in, qy_in, qz_in;
   logic signed [DATA_WIDTH-1:0] qw_ff, qx_ff, qy_ff, qz_ff;

   always_comb begin
      unique case (dv_sel)
         SEL_W: begin
            qw_in = dv_half; qx_in = p0; qy_in = p1; qz_in = p2;
         end
         SEL_X: begin
            qw_in = p0; qx_in = dv_half; qy_in = p1; qz_in = p2;
         end
         SEL_Y: begin
            qw_in = p0; qx_in = p2; qy_in = dv_half; qz_in = p1;
         end
         SEL_Z: begin
            qw_in = p0; qx_in = p1; qy_in = p2; qz_in = dv_half;
         end
         default: begin
            qw_in = '0; qx_in = '0; qy_in = '0; qz_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qw_ff <= qw_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
      end
   end

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.qw    = qw_ff;
   assign rsp_if.qx    = qx_ff;
   assign rsp_if.qy    = qy_ff;
   assign rsp_if.qz    = qz_ff;

endmodule
`default_nettype wire

// File: rtl/rmq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the converter's flow control, bound to the top level.
// ----------------------------------------------------------------------------
module rmq_checker #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [DATA_WIDTH-1:0] rsp_qw,
   input wire logic [DATA_WIDTH-1:0] rsp_qx,
   input wire logic [DATA_WIDTH-1:0] rsp_qy,
   input wire logic [DATA_WIDTH-1:0] rsp_qz
);

   // Nothing comes out of the pipeline right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // An empty output register never blocks the input.
   a_ready_when_empty : assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output is empty");

   // A stalled output freezes the whole pipeline, input included.
   a_stall_blocks : assert property (@(posedge clock)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req ready while output is stalled");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_qw) && $stable(rsp_qx)
         && $stable(rsp_qy) && $stable(rsp_qz))
      else $error("stalled rsp item changed");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_qw    (rsp_if.qw),
   .rsp_qx    (rsp_if.qx),
   .rsp_qy    (rsp_if.qy),
   .rsp_qz    (rsp_if.qz)
);
`default_nettype wire

// File: sim/tb_rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// Streams matrices into the converter and compares each quaternion with an
// in-bench fixed-point computation, in order, under random idling on both
// the sending and the receiving side.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
   import rmq_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LIMIT = 400000;

   typedef logic signed [DW-1:0] elem_type;
   typedef struct packed {
      elem_type w, x, y, z;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmq_req_if #(.DATA_WIDTH(DW)) req_if ();
   rmq_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

   rotation_matrix_to_quaternion_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quat_type quat_queue[$];
   int       n_mismatch = 0;
   int       cycles = 0;
   bit       idle_on = 1'b1;

   initial begin
      req_if.valid = 1'b0;
      req_if.r00 = '0; req_if.r01 = '0; req_if.r02 = '0;
      req_if.r10 = '0; req_if.r11 = '0; req_if.r12 = '0;
      req_if.r20 = '0; req_if.r21 = '0; req_if.r22 = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint unsigned round_root(longint unsigned v);
      longint unsigned r, b, rem;
      r = 0;
      b = 64'd1 << 62;
      rem = v;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (rem > r) r = r + 1;
      return r;
   endfunction

   function automatic longint off_term(longint d, longint unsigned s);
      longint unsigned mag, den, q;
      if (s == 0) return 0;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      den = s * 2;
      q = ((mag << FB) + den / 2) / den;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic elem_type clip(longint v);
      longint hi, lo;
      hi = (longint'(1) << (DW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return elem_type'(v);
   endfunction

   function automatic quat_type matrix_to_quat(elem_type m[9]);
      longint r[3][3];
      longint q[4];
      longint tr, arg;
      longint unsigned s, half;
      int a, b, c;
      quat_type res;
      for (int i = 0; i < 9; i++) r[i / 3][i % 3] = longint'(m[i]);
      tr = r[0][0] + r[1][1] + r[2][2];
      if (tr > 0) begin
         arg = tr + (longint'(1) << FB);
         s = round_root(longint'(arg) << FB);
         half = round_root(longint'(arg) << (FB - 2));
         q[SEL_W] = longint'(half);
         q[SEL_X] = off_term(r[1][2] - r[2][1], s);
         q[SEL_Y] = off_term(r[2][0] - r[0][2], s);
         q[SEL_Z] = off_term(r[0][1] - r[1][0], s);
      end else begin
         a = (r[0][0] < r[1][1]) ? 1 : 0;
         if (r[a][a] < r[2][2]) a = 2;
         b = (a + 1) % 3;
         c = (a + 2) % 3;
         arg = r[a][a] - (r[b][b] + r[c][c]) + (longint'(1) << FB);
         if (arg < 0) arg = 0;
         s = round_root(longint'(arg) << FB);
         half = round_root(longint'(arg) << (FB - 2));
         q[1 + a] = longint'(half);
         q[SEL_W] = off_term(r[b][c] - r[c][b], s);
         q[1 + b] = off_term(r[a][b] + r[b][a], s);
         q[1 + c] = off_term(r[a][c] + r[c][a], s);
      end
      res.w = clip(q[0]);
      res.x = clip(q[1]);
      res.y = clip(q[2]);
      res.z = clip(q[3]);
      return res;
   endfunction

   task automatic send_matrix(elem_type m[9]);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.r00 <= m[0]; req_if.r01 <= m[1]; req_if.r02 <= m[2];
      req_if.r10 <= m[3]; req_if.r11 <= m[4]; req_if.r12 <= m[5];
      req_if.r20 <= m[6]; req_if.r21 <= m[7]; req_if.r22 <= m[8];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      quat_queue.push_back(matrix_to_quat(m));
   endtask

   // Receiver: random stall bursts, then compare each taken quaternion.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            quat_type got, want;
            got = {rsp_if.qw, rsp_if.qx, rsp_if.qy, rsp_if.qz};
            if (quat_queue.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected quaternion %h", got);
            end else begin
               want = quat_queue.pop_front();
               if (got !== want) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("quat w/x/y/z exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                              want.w, want.x, want.y, want.z,
                              got.w, got.x, got.y, got.z);
               end
            end
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= (stall_left == 1);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 16);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("rotation_matrix_to_quaternion_top: mismatch");
         $finish;
      end
   end

   function automatic elem_type rand_elem();
      return elem_type'($urandom_range(0, 65535));
   endfunction

   // Near-rotation element: mostly within +-1.0, sometimes beyond.
   function automatic elem_type near_elem();
      return elem_type'(int'($urandom_range(0, 2 * 16900)) - 16900);
   endfunction

   task automatic test_directed();
      elem_type m[9];
      elem_type one, mx, mn;
      one = elem_type'(1 << FB);
      mx = elem_type'(32767);
      mn = elem_type'(-32768);
      // Identity and the three half-turn rotations pick each branch.
      m = '{one, 0, 0, 0, one, 0, 0, 0, one};            send_matrix(m);
      m = '{one, 0, 0, 0, -one, 0, 0, 0, -one};          send_matrix(m);
      m = '{-one, 0, 0, 0, one, 0, 0, 0, -one};          send_matrix(m);
      m = '{-one, 0, 0, 0, -one, 0, 0, 0, one};          send_matrix(m);
      // Equal diagonals exercise the tie order.
      m = '{0, one, 0, one, 0, 0, 0, 0, -one};           send_matrix(m);
      m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};         send_matrix(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(m);
      m = '{one, 2, 3, 4, one, 5, 6, 7, one};            send_matrix(m);
      // Extreme diagonal entries, in the trace branch and in the x branch.
      m = '{mn, 5, 5, 5, mx, 5, 5, 5, mx};               send_matrix(m);
      m = '{mn, mx, mn, mx, mn, mx, mn, mx, mn};         send_matrix(m);
      // Saturation and extremes of every field.
      m = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};         send_matrix(m);
      m = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};         send_matrix(m);
      m = '{mx, mn, mx, mn, mx, mn, mx, mn, mx};         send_matrix(m);
      m = '{mx, mx, mn, mn, 1, mx, mx, mn, 1};           send_matrix(m);
      m = '{1, mn, mx, mx, -1, mn, mn, mx, 1};           send_matrix(m);
      m = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(m);
   endtask

   task automatic test_random(int count, bit wild);
      elem_type m[9];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++)
            m[i] = (wild || $urandom_range(0, 9) == 0) ? rand_elem() : near_elem();
         send_matrix(m);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1200, 1'b0);
      test_random(200, 1'b1);
      idle_on = 1'b0;
      test_random(300, 1'b0);
      drain();
      if (n_mismatch == 0) begin
         $display("rotation_matrix_to_quaternion_top: match");
      end else begin
         $display("rotation_matrix_to_quaternion_top: mismatch");
      end
      $finish;
   end

endmodule

// File: rotation_matrix_to_quaternion_top.f
rtl/rmq_pkg.sv
rtl/rmq_req_if.sv
rtl/rmq_rsp_if.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_top.sv
rtl/rmq_checker.sv
sim/tb_rotation_matrix_to_quaternion_top.sv
